// File: hw/rtl/tslc_pkg.sv
// shared constants, types and character helpers for the token span locator
`timescale 1ns / 1ps
package tslc_pkg;

    localparam int TEXT_DEPTH = 4096;
    localparam int LINE_DEPTH = 1024;
    localparam int TIDX_W     = $clog2(TEXT_DEPTH);
    localparam int OFF_W      = 13;
    localparam int LIDX_W     = $clog2(LINE_DEPTH);
    localparam int LCNT_W     = LIDX_W + 1;

    localparam logic [1:0] MODE_CLEAR  = 2'd0;
    localparam logic [1:0] MODE_APPEND = 2'd1;
    localparam logic [1:0] MODE_QUERY  = 2'd2;

    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_USCORE = 8'h5F;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_LO_E   = 8'h65;
    localparam logic [7:0] CH_UP_E   = 8'h45;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_EQ     = 8'h3D;
    localparam logic [7:0] CH_LT     = 8'h3C;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_BANG   = 8'h21;

    typedef struct packed {
        logic              done;
        logic [LCNT_W-1:0] line;
        logic [OFF_W-1:0]  column;
    } loc_res_t;

    typedef struct packed {
        logic             done;
        logic [OFF_W-1:0] end_off;
    } scan_res_t;

    function automatic logic is_alpha(input logic [7:0] c);
        return (c inside {[8'h61:8'h7A]}) || (c inside {[8'h41:8'h5A]});
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c inside {[8'h30:8'h39]};
    endfunction

endpackage

// File: hw/rtl/tslc_ram.sv
// generic single-write, single-read ram with registered read data
`timescale 1ns / 1ps
module tslc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: hw/rtl/tslc_line_search.sv
// binary search of the line start table for the line holding an offset
`timescale 1ns / 1ps
module tslc_line_search
    import tslc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [OFF_W-1:0]  target,
    input  logic [LCNT_W-1:0] line_count,
    output logic [LIDX_W-1:0] rd_addr,
    input  logic [OFF_W-1:0]  rd_data,
    output loc_res_t          res
);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [LIDX_W-1:0] lo_reg, lo_next;
    logic [LIDX_W-1:0] hi_reg, hi_next;
    logic [LIDX_W-1:0] mid_reg, mid_next;
    logic [OFF_W-1:0]  base_reg, base_next;
    logic [OFF_W-1:0]  tgt_reg, tgt_next;
    logic [LCNT_W-1:0] last_idx;

    function automatic logic [LIDX_W-1:0] mid_of(input logic [LIDX_W-1:0] lo,
                                                 input logic [LIDX_W-1:0] hi);
        logic [LIDX_W:0] s;
        s = {1'b0, lo} + {1'b0, hi} + {{LIDX_W{1'b0}}, 1'b1};
        return s[LIDX_W:1];
    endfunction

    assign last_idx = line_count - {{(LCNT_W-1){1'b0}}, 1'b1};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        lo_next   = lo_reg;
        hi_next   = hi_reg;
        mid_next  = mid_reg;
        base_next = base_reg;
        tgt_next  = tgt_reg;
        if (start)
        begin
            tgt_next  = target;
            base_next = '0;
            lo_next   = '0;
            hi_next   = last_idx[LIDX_W-1:0];
            if (hi_next != '0)
            begin
                busy_next = 1'b1;
                mid_next  = mid_of(lo_next, hi_next);
            end
            else
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
        else if (busy_reg)
        begin
            if (rd_data <= tgt_reg)
            begin
                lo_next   = mid_reg;
                base_next = rd_data;
            end
            else
            begin
                hi_next = mid_reg - {{(LIDX_W-1){1'b0}}, 1'b1};
            end
            if (lo_next < hi_next)
            begin
                mid_next = mid_of(lo_next, hi_next);
            end
            else
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    assign rd_addr = mid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg   <= lo_next;
        hi_reg   <= hi_next;
        mid_reg  <= mid_next;
        base_reg <= base_next;
        tgt_reg  <= tgt_next;
    end

    assign res.done   = done_reg;
    assign res.line   = {1'b0, lo_reg} + {{(LCNT_W-1){1'b0}}, 1'b1};
    assign res.column = tgt_reg - base_reg + {{(OFF_W-1){1'b0}}, 1'b1};

endmodule

// File: hw/rtl/tslc_token_scan.sv
// token scanner: walks text bytes one per cycle to find the token end
`timescale 1ns / 1ps
module tslc_token_scan
    import tslc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [OFF_W-1:0]  start_off,
    input  logic [OFF_W-1:0]  text_len,
    output logic [TIDX_W-1:0] rd_addr,
    input  logic [7:0]        rd_data,
    output scan_res_t         res
);

    typedef enum logic [7:0] {
        PH_IDLE  = 8'b0000_0001,
        PH_FIRST = 8'b0000_0010,
        PH_IDENT = 8'b0000_0100,
        PH_NUM   = 8'b0000_1000,
        PH_NSIGN = 8'b0001_0000,
        PH_NEXP  = 8'b0010_0000,
        PH_QUOTE = 8'b0100_0000,
        PH_CMP   = 8'b1000_0000
    } phase_t;

    phase_t           phase_reg, phase_next;
    logic             done_reg, done_next;
    logic [OFF_W-1:0] end_reg, end_next;
    logic [7:0]       c_reg, c_next;
    logic [OFF_W-1:0] end_inc;
    logic             at_end;

    assign end_inc = end_reg + {{(OFF_W-1){1'b0}}, 1'b1};
    assign at_end  = end_reg >= text_len;

    always_comb
    begin
        phase_next = phase_reg;
        done_next  = 1'b0;
        end_next   = end_reg;
        c_next     = c_reg;
        case (phase_reg)
            PH_IDLE:
            begin
                if (start)
                begin
                    end_next = start_off;
                    if (start_off >= text_len)
                    begin
                        done_next = 1'b1;
                    end
                    else
                    begin
                        phase_next = PH_FIRST;
                    end
                end
            end
            PH_FIRST:
            begin
                c_next   = rd_data;
                end_next = end_inc;
                if (is_alpha(rd_data) || rd_data == CH_USCORE)
                begin
                    phase_next = PH_IDENT;
                end
                else if (is_digit(rd_data))
                begin
                    phase_next = PH_NUM;
                end
                else if (rd_data == CH_SQUOTE || rd_data == CH_DQUOTE)
                begin
                    phase_next = PH_QUOTE;
                end
                else if (rd_data inside {CH_LT, CH_GT, CH_BANG, CH_EQ})
                begin
                    phase_next = PH_CMP;
                end
                else
                begin
                    phase_next = PH_IDLE;
                    done_next  = 1'b1;
                end
            end
            PH_IDENT:
            begin
                if (!at_end && (is_alpha(rd_data) || is_digit(rd_data) ||
                                rd_data == CH_USCORE))
                begin
                    end_next = end_inc;
                end
                else
                begin
                    phase_next = PH_IDLE;
                    done_next  = 1'b1;
                end
            end
            PH_NUM:
            begin
                if (at_end)
                begin
                    phase_next = PH_IDLE;
                    done_next  = 1'b1;
                end
                else if (is_digit(rd_data) || rd_data == CH_DOT)
                begin
                    end_next = end_inc;
                end
                else if (rd_data == CH_LO_E || rd_data == CH_UP_E)
                begin
                    end_next   = end_inc;
                    phase_next = PH_NSIGN;
                end
                else
                begin
                    phase_next = PH_IDLE;
                    done_next  = 1'b1;
                end
            end
            PH_NSIGN:
            begin
                if (!at_end && (rd_data == CH_PLUS || rd_data == CH_MINUS ||
                                is_digit(rd_data)))
                begin
                    end_next   = end_inc;
                    phase_next = PH_NEXP;
                end
                else
                begin
                    phase_next = PH_IDLE;
                    done_next  = 1'b1;
                end
            end
            PH_NEXP:
            begin
                if (!at_end && is_digit(rd_data))
                begin
                    end_next = end_inc;
                end
                else
                begin
                    phase_next = PH_IDLE;
                    done_next  = 1'b1;
                end
            end
            PH_QUOTE:
            begin
                if (at_end)
                begin
                    phase_next = PH_IDLE;
                    done_next  = 1'b1;
                end
                else
                begin
                    end_next = end_inc;
                    if (rd_data == c_reg)
                    begin
                        phase_next = PH_IDLE;
                        done_next  = 1'b1;
                    end
                end
            end
            PH_CMP:
            begin
                if (!at_end && (rd_data == CH_EQ ||
                                (c_reg == CH_LT && rd_data == CH_GT)))
                begin
                    end_next = end_inc;
                end
                phase_next = PH_IDLE;
                done_next  = 1'b1;
            end
            default:
            begin
                phase_next = PH_IDLE;
            end
        endcase
    end

    // read the byte at the next scan position
    assign rd_addr = end_next[TIDX_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        end_reg <= end_next;
        c_reg   <= c_next;
    end

    assign res.done    = done_reg;
    assign res.end_off = end_reg;

endmodule

// File: hw/rtl/token_span_line_column_locator.sv
// top level: text and line start memories, request decode and query sequencer
//
// one input stream carries requests: tuser is the mode (clear, append, query),
// tdata the appended byte and the query offset. clear and append give no
// result. a query gives one result on the output stream once the line start
// table is searched for the start offset, the token bytes are scanned one per
// cycle, and the table is searched again for the end offset. the next request
// can be accepted once the result is loaded into the output register; an
// offset past the end of text skips the searches and the scan and goes
// straight to the final state.
// the result sits in an output register; requests keep being accepted while
// it waits, and a following query holds in its final state until the
// receiver has taken the earlier result.
// reset empties the text, sets one line starting at offset 0 and clears the
// overflow flag; no memory clearing pass is needed.
`timescale 1ns / 1ps
module token_span_line_column_locator
    import tslc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // text_byte[7:0], query_offset[20:8], zero fill
    input  logic [1:0]  s_tuser,   // mode[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata    // valid_res[0], start_line[11:1], start_column[24:12],
                                   // stop_line[35:25], stop_column[48:36], overflow[49],
                                   // zero fill
);

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_LOC_S = 5'b00010,
        ST_SCAN  = 5'b00100,
        ST_LOC_E = 5'b01000,
        ST_FIN   = 5'b10000
    } state_t;

    state_t            state_reg, state_next;
    logic [OFF_W-1:0]  len_reg, len_next;
    logic [LCNT_W-1:0] count_reg, count_next;
    logic              ovf_reg, ovf_next;
    logic              m_valid_reg, m_valid_next;
    logic [55:0]       m_data_reg, m_data_next;
    logic              vld_reg, vld_next;
    logic [LCNT_W-1:0] sl_reg, sl_next, el_reg, el_next;
    logic [OFF_W-1:0]  sc_reg, sc_next, ec_reg, ec_next;
    logic [OFF_W-1:0]  qoff_reg, qoff_next;

    logic [1:0]        mode;
    logic [7:0]        in_byte;
    logic [OFF_W-1:0]  in_off;
    logic              accept;
    logic              text_full;
    logic              line_full;
    logic              text_we;
    logic              line_we;
    logic [OFF_W-1:0]  len_inc;

    logic              srch_start;
    logic [OFF_W-1:0]  srch_target;
    logic [LIDX_W-1:0] line_raddr;
    logic [OFF_W-1:0]  line_rdata;
    loc_res_t          srch_res;
    logic              scan_start;
    logic [TIDX_W-1:0] text_raddr;
    logic [7:0]        text_rdata;
    scan_res_t         scan_res;
    logic              out_free;

    assign mode    = s_tuser;
    assign in_byte = s_tdata[7:0];
    assign in_off  = s_tdata[20:8];

    assign s_tready  = state_reg == ST_IDLE;
    assign accept    = s_tvalid && s_tready;
    assign text_full = len_reg >= OFF_W'(TEXT_DEPTH);
    assign line_full = count_reg >= LCNT_W'(LINE_DEPTH);
    assign len_inc   = len_reg + {{(OFF_W-1){1'b0}}, 1'b1};
    assign text_we   = accept && mode == MODE_APPEND && !text_full;
    assign line_we   = text_we && in_byte == CH_NL && !line_full;
    assign out_free  = !m_valid_reg || m_tready;

    assign srch_start  = (accept && mode == MODE_QUERY && in_off <= len_reg) ||
                         (state_reg == ST_SCAN && scan_res.done);
    assign srch_target = (state_reg == ST_SCAN) ? scan_res.end_off : in_off;
    assign scan_start  = state_reg == ST_LOC_S && srch_res.done;

    tslc_ram #(
        .WIDTH (8),
        .DEPTH (TEXT_DEPTH)
    ) u_text_ram (
        .clk   (clk),
        .we    (text_we),
        .waddr (len_reg[TIDX_W-1:0]),
        .wdata (in_byte),
        .raddr (text_raddr),
        .rdata (text_rdata)
    );

    tslc_ram #(
        .WIDTH (OFF_W),
        .DEPTH (LINE_DEPTH)
    ) u_line_ram (
        .clk   (clk),
        .we    (line_we),
        .waddr (count_reg[LIDX_W-1:0]),
        .wdata (len_inc),
        .raddr (line_raddr),
        .rdata (line_rdata)
    );

    tslc_line_search u_search (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (srch_start),
        .target     (srch_target),
        .line_count (count_reg),
        .rd_addr    (line_raddr),
        .rd_data    (line_rdata),
        .res        (srch_res)
    );

    tslc_token_scan u_scan (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (scan_start),
        .start_off (qoff_reg),
        .text_len  (len_reg),
        .rd_addr   (text_raddr),
        .rd_data   (text_rdata),
        .res       (scan_res)
    );

    always_comb
    begin
        state_next   = state_reg;
        len_next     = len_reg;
        count_next   = count_reg;
        ovf_next     = ovf_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        vld_next     = vld_reg;
        sl_next      = sl_reg;
        sc_next      = sc_reg;
        el_next      = el_reg;
        ec_next      = ec_reg;
        qoff_next    = qoff_reg;

        if (m_valid_reg && m_tready)
        begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (mode)
                        MODE_CLEAR:
                        begin
                            len_next   = '0;
                            count_next = {{(LCNT_W-1){1'b0}}, 1'b1};
                            ovf_next   = 1'b0;
                        end
                        MODE_APPEND:
                        begin
                            if (text_full)
                            begin
                                ovf_next = 1'b1;
                            end
                            else
                            begin
                                len_next = len_inc;
                                if (in_byte == CH_NL)
                                begin
                                    if (line_full)
                                    begin
                                        ovf_next = 1'b1;
                                    end
                                    else
                                    begin
                                        count_next = count_reg +
                                                     {{(LCNT_W-1){1'b0}}, 1'b1};
                                    end
                                end
                            end
                        end
                        MODE_QUERY:
                        begin
                            qoff_next = in_off;
                            if (in_off <= len_reg)
                            begin
                                vld_next   = 1'b1;
                                state_next = ST_LOC_S;
                            end
                            else
                            begin
                                vld_next   = 1'b0;
                                sl_next    = '0;
                                sc_next    = '0;
                                el_next    = '0;
                                ec_next    = '0;
                                state_next = ST_FIN;
                            end
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_LOC_S:
            begin
                if (srch_res.done)
                begin
                    sl_next    = srch_res.line;
                    sc_next    = srch_res.column;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (scan_res.done)
                begin
                    state_next = ST_LOC_E;
                end
            end
            ST_LOC_E:
            begin
                if (srch_res.done)
                begin
                    el_next    = srch_res.line;
                    ec_next    = srch_res.column;
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                if (out_free)
                begin
                    m_valid_next = 1'b1;
                    m_data_next  = {6'd0, ovf_reg, ec_reg, el_reg, sc_reg, sl_reg, vld_reg};
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            len_reg     <= '0;
            count_reg   <= {{(LCNT_W-1){1'b0}}, 1'b1};
            ovf_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            len_reg     <= len_next;
            count_reg   <= count_next;
            ovf_reg     <= ovf_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        m_data_reg <= m_data_next;
        vld_reg    <= vld_next;
        sl_reg     <= sl_next;
        sc_reg     <= sc_next;
        el_reg     <= el_next;
        ec_reg     <= ec_next;
        qoff_reg   <= qoff_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

// File: hw/rtl/tslc_checker.sv
// port-level checks for the token span locator, bound to the top level
`timescale 1ns / 1ps
module tslc_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [55:0] m_tdata
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // an out-of-range request reports all positions as zero
    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tdata[0] |-> m_tdata[48:1] == 48'd0)
        else $error("invalid result with nonzero position");

    // a located token never ends on an earlier line than it starts
    a_line_order: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[0] |-> m_tdata[11:1] != 11'd0 &&
                                   m_tdata[35:25] >= m_tdata[11:1])
        else $error("end line before start line");

    // columns are 1-based
    a_col_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[0] |-> m_tdata[24:12] != 13'd0 && m_tdata[48:36] != 13'd0)
        else $error("zero column in valid result");

endmodule

bind token_span_line_column_locator tslc_checker u_tslc_checker (.*);

// File: bench/tb_token_span_line_column_locator.sv
// self-checking testbench for the token span line/column locator
`timescale 1ns / 1ps
module tb_token_span_line_column_locator;
    import tslc_pkg::*;

    localparam logic [1:0] MODE_UNUSED    = 2'd3;
    localparam int         RANDOM_ITEMS   = 400;
    localparam int         RX_HOLD_CYCLES = 400;
    localparam int         QUIET_LIMIT    = 20000;
    localparam int         END_CYCLES     = 100;

    typedef struct {
        logic [1:0]       mode;
        logic [7:0]       text_byte;
        logic [OFF_W-1:0] query_offset;
        int unsigned      gap;
    } locator_req_t;

    typedef struct packed {
        logic              valid_res;
        logic [LCNT_W-1:0] start_line;
        logic [OFF_W-1:0]  start_column;
        logic [LCNT_W-1:0] stop_line;
        logic [OFF_W-1:0]  stop_column;
        logic              overflow;
    } span_loc_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata = '0;         // text_byte[7:0], query_offset[20:8], zero fill
    logic [1:0]  s_tuser = MODE_CLEAR; // mode[1:0]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [55:0] m_tdata;              // valid_res[0], start_line[11:1], start_column[24:12],
                                       // stop_line[35:25], stop_column[48:36], overflow[49]

    token_span_line_column_locator DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #5 clk = ~clk;

    // local copy of the text and line table
    logic [7:0]   txt_mem [TEXT_DEPTH];
    int unsigned  txt_len;
    int unsigned  line_starts [LINE_DEPTH];
    int unsigned  line_cnt;
    logic         ovf_seen;

    locator_req_t req_backlog [$];
    span_loc_t    span_expected [$];
    int           mismatches = 0;
    int           quiet_cycles = 0;
    logic         req_taken = 1'b0;
    logic         res_taken = 1'b0;
    int unsigned  tx_wait = 0;
    bit           tx_quiet = 1'b0;
    bit           rx_quiet = 1'b0;
    int           rx_stall = 0;
    int           hold_requests = 0;
    int           hold_seen = 0;
    int unsigned  plan_len = 0;
    int unsigned  items_queued = 0;

    function automatic void reset_text_model();
        txt_len        = 0;
        line_starts[0] = 0;
        line_cnt       = 1;
        ovf_seen       = 1'b0;
    endfunction

    function automatic bit is_letter(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic bit is_numeral(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic void find_line_col(input int unsigned off,
                                          output logic [LCNT_W-1:0] line,
                                          output logic [OFF_W-1:0] col);
        int unsigned idx;
        int unsigned i;
        idx = 0;
        for (i = 1; i < line_cnt; i++) begin
            if (line_starts[i] <= off)
                idx = i;
            else
                break;
        end
        line = LCNT_W'(idx + 1);
        col  = OFF_W'(off - line_starts[idx] + 1);
    endfunction

    function automatic int unsigned scan_token_end(input int unsigned start);
        int unsigned stop;
        logic [7:0]  c0;
        if (start >= txt_len)
            return start;
        c0   = txt_mem[start];
        stop = start + 1;
        if (is_letter(c0) || c0 == CH_USCORE) begin
            while (stop < txt_len && (is_letter(txt_mem[stop]) || is_numeral(txt_mem[stop])
                                      || txt_mem[stop] == CH_USCORE))
                stop++;
        end
        else if (is_numeral(c0)) begin
            while (stop < txt_len && (is_numeral(txt_mem[stop]) || txt_mem[stop] == CH_DOT))
                stop++;
            if (stop < txt_len && (txt_mem[stop] == CH_LO_E || txt_mem[stop] == CH_UP_E)) begin
                stop++;
                if (stop < txt_len && (txt_mem[stop] == CH_PLUS || txt_mem[stop] == CH_MINUS))
                    stop++;
                while (stop < txt_len && is_numeral(txt_mem[stop]))
                    stop++;
            end
        end
        else if (c0 == CH_SQUOTE || c0 == CH_DQUOTE) begin
            while (stop < txt_len && txt_mem[stop] != c0)
                stop++;
            if (stop < txt_len)
                stop++;
        end
        else if (c0 == CH_LT || c0 == CH_GT || c0 == CH_BANG || c0 == CH_EQ) begin
            if (stop < txt_len && txt_mem[stop] == CH_EQ)
                stop++;
            else if (c0 == CH_LT && stop < txt_len && txt_mem[stop] == CH_GT)
                stop++;
        end
        return stop;
    endfunction

    function automatic void record_request(input logic [1:0] mode, input logic [7:0] b,
                                           input logic [OFF_W-1:0] qoff);
        span_loc_t   want;
        int unsigned off;
        off = qoff;
        case (mode)
            MODE_CLEAR:
                reset_text_model();
            MODE_APPEND:
            begin
                if (txt_len >= TEXT_DEPTH)
                    ovf_seen = 1'b1;
                else
                begin
                    txt_mem[txt_len] = b;
                    txt_len++;
                    if (b == CH_NL)
                    begin
                        if (line_cnt < LINE_DEPTH)
                        begin
                            line_starts[line_cnt] = txt_len;
                            line_cnt++;
                        end
                        else
                            ovf_seen = 1'b1;
                    end
                end
            end
            MODE_QUERY:
            begin
                want          = '0;
                want.overflow = ovf_seen;
                if (off <= txt_len)
                begin
                    want.valid_res = 1'b1;
                    find_line_col(off, want.start_line, want.start_column);
                    find_line_col(scan_token_end(off), want.stop_line, want.stop_column);
                end
                span_expected = {span_expected, want};
            end
            default:
                ;
        endcase
    endfunction

    function automatic void check_field(input string field, input int unsigned want,
                                        input int unsigned got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", field, want, got);
            mismatches++;
        end
    endfunction

    // request driver
    always @(negedge clk)
    begin : driver_proc
        logic         offer;
        locator_req_t cur;
        if (rst_n)
        begin
            offer = s_tvalid && !req_taken;
            if (!offer && req_backlog.size() > 0)
            begin
                if (tx_wait < req_backlog[0].gap)
                    tx_wait++;
                else
                begin
                    cur     = req_backlog.pop_front();
                    tx_wait = 0;
                    offer   = 1'b1;
                    s_tuser <= cur.mode;
                    s_tdata <= {3'b000, cur.query_offset, cur.text_byte};
                end
            end
            s_tvalid <= offer;
        end
    end

    // result receiver
    always @(negedge clk)
    begin : receiver_proc
        if (rst_n)
        begin
            if (res_taken)
                rx_stall = rx_quiet ? 0 : $urandom_range(0, 19);
            if (hold_seen != hold_requests)
            begin
                hold_seen = hold_requests;
                rx_stall  = RX_HOLD_CYCLES;
            end
            if (rx_stall > 0)
            begin
                rx_stall--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= 1'b1;
        end
    end

    // monitor and checker
    always @(posedge clk)
    begin : monitor_proc
        span_loc_t got;
        span_loc_t want;
        if (rst_n)
        begin
            req_taken <= s_tvalid && s_tready;
            res_taken <= m_tvalid && m_tready;
            if (m_tvalid && m_tready)
            begin
                got.valid_res    = m_tdata[0];
                got.start_line   = m_tdata[11:1];
                got.start_column = m_tdata[24:12];
                got.stop_line    = m_tdata[35:25];
                got.stop_column  = m_tdata[48:36];
                got.overflow     = m_tdata[49];
                if (span_expected.size() == 0)
                begin
                    $error("result with no pending query");
                    mismatches++;
                end
                else
                begin
                    want = span_expected.pop_front();
                    check_field("valid_res", want.valid_res, got.valid_res);
                    check_field("start_line", want.start_line, got.start_line);
                    check_field("start_column", want.start_column, got.start_column);
                    check_field("stop_line", want.stop_line, got.stop_line);
                    check_field("stop_column", want.stop_column, got.stop_column);
                    check_field("overflow", want.overflow, got.overflow);
                end
            end
            if (s_tvalid && s_tready)
                record_request(s_tuser, s_tdata[7:0], s_tdata[20:8]);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
    end

    always @(posedge clk)
    begin : watchdog_proc
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("token_span_line_column_locator: mismatch");
            $finish;
        end
    end

    task automatic queue_request(input logic [1:0] mode, input logic [7:0] b,
                                 input int unsigned off);
        locator_req_t r;
        r.mode         = mode;
        r.text_byte    = b;
        r.query_offset = OFF_W'(off);
        r.gap          = tx_quiet ? 0 : $urandom_range(0, 19);
        req_backlog    = {req_backlog, r};
        items_queued++;
        if (mode == MODE_CLEAR)
            plan_len = 0;
        else if (mode == MODE_APPEND && plan_len < TEXT_DEPTH)
            plan_len++;
    endtask

    task automatic append_text(input string s);
        int i;
        for (i = 0; i < s.len(); i++)
            queue_request(MODE_APPEND, s[i], 0);
    endtask

    task automatic append_random_token();
        string ident_chars;
        string punct_chars;
        int    n;
        int    i;
        byte   q;
        ident_chars = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789_";
        punct_chars = "@[`{/:()*,;.+-";
        case ($urandom_range(0, 9))
            0, 1:
            begin
                queue_request(MODE_APPEND, ident_chars[$urandom_range(0, 51)], 0);
                if ($urandom_range(0, 3) == 0)
                    queue_request(MODE_APPEND, CH_USCORE, 0);
                n = $urandom_range(0, 5);
                for (i = 0; i < n; i++)
                    queue_request(MODE_APPEND, ident_chars[$urandom_range(0, 62)], 0);
            end
            2, 3:
            begin
                n = $urandom_range(1, 3);
                for (i = 0; i < n; i++)
                    queue_request(MODE_APPEND, 8'("0" + $urandom_range(0, 9)), 0);
                if ($urandom_range(0, 1) == 0)
                    queue_request(MODE_APPEND, CH_DOT, 0);
                if ($urandom_range(0, 1) == 0)
                begin
                    queue_request(MODE_APPEND, $urandom_range(0, 1) ? CH_LO_E : CH_UP_E, 0);
                    if ($urandom_range(0, 1) == 0)
                        queue_request(MODE_APPEND, $urandom_range(0, 1) ? CH_PLUS : CH_MINUS, 0);
                    n = $urandom_range(0, 2);
                    for (i = 0; i < n; i++)
                        queue_request(MODE_APPEND, 8'("0" + $urandom_range(0, 9)), 0);
                end
            end
            4:
            begin
                q = $urandom_range(0, 1) ? CH_SQUOTE : CH_DQUOTE;
                queue_request(MODE_APPEND, q, 0);
                n = $urandom_range(0, 4);
                for (i = 0; i < n; i++)
                    queue_request(MODE_APPEND, ident_chars[$urandom_range(0, 62)], 0);
                if ($urandom_range(0, 4) != 0)
                    queue_request(MODE_APPEND, q, 0);
            end
            5:
            begin
                case ($urandom_range(0, 3))
                    0: queue_request(MODE_APPEND, CH_LT, 0);
                    1: queue_request(MODE_APPEND, CH_GT, 0);
                    2: queue_request(MODE_APPEND, CH_BANG, 0);
                    default: queue_request(MODE_APPEND, CH_EQ, 0);
                endcase
                case ($urandom_range(0, 2))
                    0: queue_request(MODE_APPEND, CH_EQ, 0);
                    1: queue_request(MODE_APPEND, CH_GT, 0);
                    default: ;
                endcase
            end
            6:
                queue_request(MODE_APPEND, " ", 0);
            7:
                queue_request(MODE_APPEND, CH_NL, 0);
            8:
                queue_request(MODE_APPEND, punct_chars[$urandom_range(0, 13)], 0);
            default:
                queue_request(MODE_APPEND, 8'($urandom_range(0, 255)), 0);
        endcase
    endtask

    task automatic queue_random_query();
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5, 6:
                queue_request(MODE_QUERY, 8'($urandom_range(0, 255)),
                              $urandom_range(0, plan_len));
            7: queue_request(MODE_QUERY, 8'($urandom_range(0, 255)), plan_len);
            8: queue_request(MODE_QUERY, 8'($urandom_range(0, 255)), plan_len + 1);
            default:
                queue_request(MODE_QUERY, 8'($urandom_range(0, 255)),
                              $urandom_range(0, 8191));
        endcase
    endtask

    task automatic wait_until_drained();
        do
            @(posedge clk);
        while (req_backlog.size() != 0 || s_tvalid || span_expected.size() != 0);
    endtask

    task automatic run_random_sessions(input int unsigned count);
        int unsigned stop_at;
        int          n;
        int          i;
        stop_at = items_queued + count;
        while (items_queued < stop_at)
        begin
            tx_quiet = ($urandom_range(0, 3) == 0);
            rx_quiet = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 4) != 0)
                queue_request(MODE_CLEAR, 8'($urandom_range(0, 255)), $urandom_range(0, 8191));
            n = $urandom_range(4, 16);
            for (i = 0; i < n; i++)
                append_random_token();
            n = $urandom_range(3, 8);
            for (i = 0; i < n; i++)
            begin
                case ($urandom_range(0, 9))
                    0: queue_request(MODE_UNUSED, 8'($urandom_range(0, 255)),
                                     $urandom_range(0, 8191));
                    1: append_random_token();
                    default: queue_random_query();
                endcase
            end
            if ($urandom_range(0, 5) == 0)
                wait_until_drained();
        end
    endtask

    initial
    begin : stimulus_proc
        int i;
        reset_text_model();
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: every token kind, end of text, past end, unused mode
        tx_quiet = 1'b1;
        queue_request(MODE_QUERY, 8'hFF, 0);
        queue_request(MODE_CLEAR, 8'h00, 0);
        append_text("x_1 2.e+5'a'<>!=>\n\"q");
        queue_request(MODE_QUERY, 8'h00, 0);
        queue_request(MODE_QUERY, 8'h00, 3);
        queue_request(MODE_QUERY, 8'h00, 4);
        queue_request(MODE_QUERY, 8'h00, 9);
        queue_request(MODE_QUERY, 8'h00, 12);
        queue_request(MODE_QUERY, 8'h00, 14);
        queue_request(MODE_QUERY, 8'h00, 16);
        queue_request(MODE_QUERY, 8'h00, 17);
        queue_request(MODE_QUERY, 8'h00, 18);
        queue_request(MODE_QUERY, 8'h00, 20);
        queue_request(MODE_QUERY, 8'h00, 21);
        queue_request(MODE_UNUSED, 8'hFF, 8191);
        queue_request(MODE_QUERY, 8'hFF, 8191);
        wait_until_drained();

        run_random_sessions(RANDOM_ITEMS / 2);
        wait_until_drained();

        // long receiver hold-off while queries keep coming
        tx_quiet = 1'b1;
        hold_requests++;
        queue_request(MODE_CLEAR, 8'h00, 0);
        append_text("ab <= 12e3\n'q'");
        for (i = 0; i < 8; i++)
            queue_random_query();
        wait_until_drained();

        run_random_sessions(RANDOM_ITEMS / 2);
        wait_until_drained();

        // line table overflow, then text overflow with dropped newlines
        tx_quiet = 1'b0;
        rx_quiet = 1'b0;
        queue_request(MODE_CLEAR, 8'h00, 0);
        for (i = 0; i < LINE_DEPTH + 6; i++)
            queue_request(MODE_APPEND, CH_NL, 0);
        queue_request(MODE_QUERY, 8'h00, 0);
        queue_request(MODE_QUERY, 8'h00, LINE_DEPTH - 1);
        queue_request(MODE_QUERY, 8'h00, LINE_DEPTH + 3);
        queue_request(MODE_QUERY, 8'h00, LINE_DEPTH + 6);
        tx_quiet = 1'b1;
        while (plan_len < TEXT_DEPTH)
            append_random_token();
        append_text("\nz\n");
        tx_quiet = 1'b0;
        queue_request(MODE_QUERY, 8'h00, TEXT_DEPTH - 1);
        queue_request(MODE_QUERY, 8'h00, TEXT_DEPTH);
        queue_request(MODE_QUERY, 8'h00, TEXT_DEPTH + 1);
        for (i = 0; i < 6; i++)
            queue_random_query();
        queue_request(MODE_CLEAR, 8'h00, 0);
        queue_request(MODE_QUERY, 8'h00, 0);
        queue_request(MODE_QUERY, 8'h00, 1);
        wait_until_drained();

        repeat (END_CYCLES) @(posedge clk);
        if (span_expected.size() != 0)
        begin
            $error("%0d expected results never arrived", span_expected.size());
            mismatches++;
        end
        if (mismatches == 0)
            $display("token_span_line_column_locator: match");
        else
            $display("token_span_line_column_locator: mismatch");
        $finish;
    end

endmodule
